/* rtl/core/bss_pkg.sv */
package bss_pkg;

   localparam int CAPACITY = 256;
   localparam int VALUE_W  = 32;
   localparam int POS_W    = $clog2(CAPACITY + 1);
   localparam int COUNT_W  = $clog2(CAPACITY + 1);

   typedef enum logic [2:0] {
      CMD_PUSH_BACK  = 3'd0,
      CMD_PUSH_FRONT = 3'd1,
      CMD_POP_BACK   = 3'd2,
      CMD_POP_FRONT  = 3'd3,
      CMD_INSERT     = 3'd4,
      CMD_REMOVE     = 3'd5,
      CMD_CLEAR      = 3'd6,
      CMD_READ       = 3'd7
   } cmd_type;

   typedef enum logic [1:0] {
      ST_DONE    = 2'd0,
      ST_IGNORED = 2'd1,
      ST_FULL    = 2'd2
   } status_type;

   typedef struct packed {
      cmd_type                     command;
      logic [POS_W-1:0]            position;
      logic signed [VALUE_W-1:0]   value;
   } req_type;

   typedef struct packed {
      status_type                  status;
      logic signed [VALUE_W-1:0]   front_value;
      logic signed [VALUE_W-1:0]   back_value;
      logic signed [VALUE_W-1:0]   read_value;
      logic [COUNT_W-1:0]          count;
      logic                        empty_res;
   } rsp_type;

endpackage

/* rtl/core/bss_ram.sv */
module bss_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

/* rtl/core/bss_ring_addr.sv */
// Logical index to physical slot: (head + index) mod CAPACITY.
// head < CAPACITY and index <= CAPACITY, so one subtract covers the wrap.
module bss_ring_addr #(
   parameter int CAPACITY = 256
) (
   input  logic [$clog2(CAPACITY)-1:0]   head,
   input  logic [$clog2(CAPACITY+1)-1:0] index,
   output logic [$clog2(CAPACITY)-1:0]   slot
);

   localparam int SLOT_W = $clog2(CAPACITY);
   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int SUM_W  = CNT_W + 1;

   logic [SUM_W-1:0] sum;
   logic [SUM_W-1:0] wrapped;

   assign sum     = SUM_W'(head) + SUM_W'(index);
   assign wrapped = (sum >= SUM_W'(CAPACITY)) ? sum - SUM_W'(CAPACITY) : sum;
   assign slot    = wrapped[SLOT_W-1:0];

endmodule

/* rtl/core/bounded_sequence_store.sv */
// Flow: IDLE takes the request, EXEC decides, PEEK_FRONT, PEEK_BACK and PEEK_DONE fetch front
// and back, then RESP; a store that ends empty goes from PEEK_FRONT straight to RESP, and
// insert and remove in the middle pass through SHIFT and FINISH before PEEK_FRONT. One command
// at a time: req_ready returns the cycle after the response transfer. A mid-sequence insert or
// remove is paced by the one-read/one-write memory, which the shift walks one slot per cycle.
// Reset (synchronous, active high): store empty, head slot 0; memory contents are not cleared.
module bounded_sequence_store (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  bss_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output bss_pkg::rsp_type rsp_data
);

   localparam int CAPACITY  = bss_pkg::CAPACITY;
   localparam int SLOT_W    = $clog2(CAPACITY);
   localparam int CNT_W     = $clog2(CAPACITY + 1);
   localparam int POS_W     = bss_pkg::POS_W;
   localparam int VALUE_W   = bss_pkg::VALUE_W;
   localparam int OUT_CNT_W = bss_pkg::COUNT_W;
   localparam int CMP_W     = (CNT_W > POS_W) ? CNT_W : POS_W;

   // Sequencer: EXEC decides, SHIFT walks the memory, PEEK_* fetch front and back.
   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_SHIFT,
      S_FINISH,
      S_PEEK_FRONT,
      S_PEEK_BACK,
      S_PEEK_DONE,
      S_RESP
   } state_type;

   state_type               state_ff,  state_in;
   bss_pkg::cmd_type        cmd_ff,    cmd_in;
   logic [POS_W-1:0]        pos_ff,    pos_in;
   logic [VALUE_W-1:0]      val_ff,    val_in;
   logic [CNT_W-1:0]        count_ff,  count_in;
   logic [SLOT_W-1:0]       head_ff,   head_in;
   logic [CNT_W-1:0]        rd_idx_ff, rd_idx_in;
   logic [CNT_W-1:0]        wr_idx_ff, wr_idx_in;
   logic [CNT_W-1:0]        rem_ff,    rem_in;
   logic                    pend_ff,   pend_in;
   bss_pkg::status_type     status_ff, status_in;
   logic [VALUE_W-1:0]      front_ff,  front_in;
   logic [VALUE_W-1:0]      back_ff,   back_in;
   logic [VALUE_W-1:0]      read_ff,   read_in;

   // memory port controls
   logic                    mem_we;
   logic                    wr_direct;
   logic [CNT_W-1:0]        wr_idx;
   logic [CNT_W-1:0]        rd_idx;
   logic [VALUE_W-1:0]      mem_wdata;
   logic [SLOT_W-1:0]       wr_slot;
   logic [SLOT_W-1:0]       rd_slot;
   logic [SLOT_W-1:0]       mem_waddr;
   logic [VALUE_W-1:0]      mem_rdata;

   // decision terms
   logic [SLOT_W-1:0]       head_dec;
   logic [SLOT_W-1:0]       head_inc;
   logic [CNT_W-1:0]        pos_idx;
   logic                    is_full;
   logic                    store_empty;
   logic                    pos_gt;
   logic                    pos_ge;
   logic                    pos_zero;
   logic                    pos_last;

   assign head_dec    = (head_ff == '0) ? SLOT_W'(CAPACITY - 1) : head_ff - 1'b1;
   assign head_inc    = (head_ff == SLOT_W'(CAPACITY - 1)) ? '0 : head_ff + 1'b1;
   // position is used as an index only once it is known to be below count
   assign pos_idx     = CNT_W'(pos_ff);
   assign is_full     = (count_ff == CNT_W'(CAPACITY));
   assign store_empty = (count_ff == '0);
   assign pos_gt      = (CMP_W'(pos_ff) >  CMP_W'(count_ff));
   assign pos_ge      = (CMP_W'(pos_ff) >= CMP_W'(count_ff));
   assign pos_zero    = (pos_ff == '0);
   assign pos_last    = (pos_idx + 1'b1 == count_ff);

   always_comb begin
      logic do_pb;
      logic do_pf;
      logic do_popb;
      logic do_popf;
      logic do_shift;

      do_pb     = 1'b0;
      do_pf     = 1'b0;
      do_popb   = 1'b0;
      do_popf   = 1'b0;
      do_shift  = 1'b0;

      state_in  = state_ff;
      cmd_in    = cmd_ff;
      pos_in    = pos_ff;
      val_in    = val_ff;
      count_in  = count_ff;
      head_in   = head_ff;
      rd_idx_in = rd_idx_ff;
      wr_idx_in = wr_idx_ff;
      rem_in    = rem_ff;
      pend_in   = pend_ff;
      status_in = status_ff;
      front_in  = front_ff;
      back_in   = back_ff;
      read_in   = read_ff;

      mem_we    = 1'b0;
      wr_direct = 1'b0;
      wr_idx    = '0;
      rd_idx    = '0;
      mem_wdata = val_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in    = req_data.command;
               pos_in    = req_data.position;
               val_in    = req_data.value;
               status_in = bss_pkg::ST_DONE;
               read_in   = '0;
               state_in  = S_EXEC;
            end
         end

         S_EXEC: begin
            unique case (cmd_ff)
               bss_pkg::CMD_PUSH_BACK: begin
                  if (is_full) status_in = bss_pkg::ST_FULL;
                  else         do_pb = 1'b1;
               end
               bss_pkg::CMD_PUSH_FRONT: begin
                  if (is_full) status_in = bss_pkg::ST_FULL;
                  else         do_pf = 1'b1;
               end
               bss_pkg::CMD_POP_BACK: begin
                  if (store_empty) status_in = bss_pkg::ST_IGNORED;
                  else             do_popb = 1'b1;
               end
               bss_pkg::CMD_POP_FRONT: begin
                  if (store_empty) status_in = bss_pkg::ST_IGNORED;
                  else             do_popf = 1'b1;
               end
               bss_pkg::CMD_INSERT: begin
                  // range checks take priority over the full check
                  priority if (store_empty || pos_gt) begin
                     status_in = bss_pkg::ST_IGNORED;
                  end else if (is_full) begin
                     status_in = bss_pkg::ST_FULL;
                  end else if (pos_zero) begin
                     do_pf = 1'b1;
                  end else if (pos_idx == count_ff) begin
                     do_pb = 1'b1;
                  end else begin
                     // walk from the back down to position, one slot up each
                     do_shift  = 1'b1;
                     rd_idx_in = count_ff - 1'b1;
                     rem_in    = count_ff - pos_idx;
                  end
               end
               bss_pkg::CMD_REMOVE: begin
                  priority if (store_empty || pos_ge) begin
                     status_in = bss_pkg::ST_IGNORED;
                  end else if (pos_zero) begin
                     do_popf = 1'b1;
                  end else if (pos_last) begin
                     do_popb = 1'b1;
                  end else begin
                     // walk from position+1 up to the back, one slot down each
                     do_shift  = 1'b1;
                     rd_idx_in = pos_idx + 1'b1;
                     rem_in    = count_ff - 1'b1 - pos_idx;
                  end
               end
               bss_pkg::CMD_CLEAR: begin
                  count_in = '0;
                  head_in  = '0;
               end
               bss_pkg::CMD_READ: begin
                  if (pos_ge) status_in = bss_pkg::ST_IGNORED;
                  else        rd_idx    = pos_idx;   // captured in PEEK_FRONT
               end
            endcase

            if (do_pb) begin
               mem_we   = 1'b1;
               wr_idx   = count_ff;
               count_in = count_ff + 1'b1;
            end
            if (do_pf) begin
               mem_we    = 1'b1;
               wr_direct = 1'b1;
               head_in   = head_dec;
               count_in  = count_ff + 1'b1;
            end
            if (do_popb) begin
               count_in = count_ff - 1'b1;
            end
            if (do_popf) begin
               head_in  = head_inc;
               count_in = count_ff - 1'b1;
            end
            pend_in  = 1'b0;
            state_in = do_shift ? S_SHIFT : S_PEEK_FRONT;
         end

         S_SHIFT: begin
            // read one element ahead, write the one read last cycle
            mem_we    = pend_ff;
            wr_idx    = wr_idx_ff;
            mem_wdata = mem_rdata;
            if (rem_ff != '0) begin
               rd_idx  = rd_idx_ff;
               pend_in = 1'b1;
               rem_in  = rem_ff - 1'b1;
               if (cmd_ff == bss_pkg::CMD_INSERT) begin
                  wr_idx_in = rd_idx_ff + 1'b1;
                  rd_idx_in = rd_idx_ff - 1'b1;
               end else begin
                  wr_idx_in = rd_idx_ff - 1'b1;
                  rd_idx_in = rd_idx_ff + 1'b1;
               end
            end else begin
               pend_in  = 1'b0;
               state_in = S_FINISH;
            end
         end

         S_FINISH: begin
            if (cmd_ff == bss_pkg::CMD_INSERT) begin
               mem_we   = 1'b1;
               wr_idx   = pos_idx;
               count_in = count_ff + 1'b1;
            end else begin
               count_in = count_ff - 1'b1;
            end
            state_in = S_PEEK_FRONT;
         end

         S_PEEK_FRONT: begin
            if (cmd_ff == bss_pkg::CMD_READ && status_ff == bss_pkg::ST_DONE) begin
               read_in = mem_rdata;
            end
            if (store_empty) begin
               front_in = '0;
               back_in  = '0;
               state_in = S_RESP;
            end else begin
               rd_idx   = '0;
               state_in = S_PEEK_BACK;
            end
         end

         S_PEEK_BACK: begin
            front_in = mem_rdata;
            rd_idx   = count_ff - 1'b1;
            state_in = S_PEEK_DONE;
         end

         S_PEEK_DONE: begin
            back_in  = mem_rdata;
            state_in = S_RESP;
         end

         S_RESP: begin
            if (rsp_ready) state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         head_ff  <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         head_ff  <= head_in;
         pend_ff  <= pend_in;
      end
      cmd_ff    <= cmd_in;
      pos_ff    <= pos_in;
      val_ff    <= val_in;
      rd_idx_ff <= rd_idx_in;
      wr_idx_ff <= wr_idx_in;
      rem_ff    <= rem_in;
      status_ff <= status_in;
      front_ff  <= front_in;
      back_ff   <= back_in;
      read_ff   <= read_in;
   end

   bss_ring_addr #(.CAPACITY(CAPACITY)) u_wr_addr (
      .head  (head_ff),
      .index (wr_idx),
      .slot  (wr_slot)
   );

   bss_ring_addr #(.CAPACITY(CAPACITY)) u_rd_addr (
      .head  (head_ff),
      .index (rd_idx),
      .slot  (rd_slot)
   );

   // push front writes at the new head, ahead of the head register update
   assign mem_waddr = wr_direct ? head_dec : wr_slot;

   bss_ram #(.WIDTH(VALUE_W), .DEPTH(CAPACITY)) u_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (rd_slot),
      .rd_data (mem_rdata)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);

   assign rsp_data.status      = status_ff;
   assign rsp_data.front_value = front_ff;
   assign rsp_data.back_value  = back_ff;
   assign rsp_data.read_value  = read_ff;
   assign rsp_data.count       = OUT_CNT_W'(count_ff);
   assign rsp_data.empty_res   = store_empty;

endmodule

/* rtl/core/bss_checker.sv */
module bss_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  bss_pkg::rsp_type rsp_data
);

   localparam int COUNT_W = bss_pkg::COUNT_W;

   // one command in flight: never open for a request while a response waits
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request ready while response pending");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.empty_res |->
         rsp_data.count == '0 && rsp_data.front_value == '0 && rsp_data.back_value == '0)
      else $error("empty response with nonzero fields");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == bss_pkg::ST_FULL |->
         rsp_data.count == COUNT_W'(bss_pkg::CAPACITY))
      else $error("full status below capacity");

   // a request transfer is never answered early
   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !rsp_valid ##1 !rsp_valid)
      else $error("response too early");

endmodule

bind bounded_sequence_store bss_checker u_bss_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
